// ----- rtl/m4t_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4t_pkg: shared types, constants and helpers
// Fixed-point word format, command codes, saturation helpers and the
// arctangent table used by the sine/cosine unit.
// ----------------------------------------------------------------------------
package m4t_pkg;

	localparam int WORD_W = 32;
	localparam int FRAC_W = 16;

	localparam logic signed [WORD_W-1:0] ONE_Q = WORD_W'(1 << FRAC_W);
	localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

	// angle constants in degrees, word fraction
	localparam int FULL_DEG  = 360 << FRAC_W;
	localparam int HALF_DEG  = 180 << FRAC_W;
	localparam int QUART_DEG = 90 << FRAC_W;

	localparam int CORDIC_STEPS = 24;
	localparam int CORDIC_X0    = 652032874;

	typedef enum logic [2:0] {
		CMD_IDENT     = 3'd0,
		CMD_WRITE     = 3'd1,
		CMD_PREMUL    = 3'd2,
		CMD_TRANSPOSE = 3'd3,
		CMD_NORMALIZE = 3'd4,
		CMD_XFORM     = 3'd5,
		CMD_ROTATE    = 3'd6,
		CMD_NOP       = 3'd7
	} cmd_t;

	// magnitude of a signed word
	function automatic logic [WORD_W-1:0] mag32(input logic signed [WORD_W-1:0] a);
		return a[WORD_W-1] ? (~a + 1'b1) : a;
	endfunction

	// signed word from magnitude and sign, saturated
	function automatic logic signed [WORD_W-1:0] sat_mag(input logic [47:0] m,
		input logic neg);
		if (neg) begin
			if (m >= 48'h0000_8000_0000)
				return WORD_MIN;
			return ~m[WORD_W-1:0] + 1'b1;
		end
		if (m > 48'h0000_7fff_ffff)
			return WORD_MAX;
		return m[WORD_W-1:0];
	endfunction

	function automatic logic signed [WORD_W-1:0] sat_add(input logic signed [WORD_W-1:0] a,
		input logic signed [WORD_W-1:0] b);
		logic signed [WORD_W:0] s;
		s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
		if (s[WORD_W] != s[WORD_W-1])
			return s[WORD_W] ? WORD_MIN : WORD_MAX;
		return s[WORD_W-1:0];
	endfunction

	function automatic logic signed [WORD_W-1:0] sat_sub(input logic signed [WORD_W-1:0] a,
		input logic signed [WORD_W-1:0] b);
		logic signed [WORD_W:0] s;
		s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
		if (s[WORD_W] != s[WORD_W-1])
			return s[WORD_W] ? WORD_MIN : WORD_MAX;
		return s[WORD_W-1:0];
	endfunction

	// atan(2^-i) in degrees, 24 fraction bits
	function automatic logic [31:0] atan_deg(input logic [4:0] i);
		case (i)
			5'd0:  return 32'd754974720;
			5'd1:  return 32'd445687602;
			5'd2:  return 32'd235489088;
			5'd3:  return 32'd119537938;
			5'd4:  return 32'd60000934;
			5'd5:  return 32'd30029717;
			5'd6:  return 32'd15018523;
			5'd7:  return 32'd7509720;
			5'd8:  return 32'd3754917;
			5'd9:  return 32'd1877466;
			5'd10: return 32'd938734;
			5'd11: return 32'd469367;
			5'd12: return 32'd234684;
			5'd13: return 32'd117342;
			5'd14: return 32'd58671;
			5'd15: return 32'd29335;
			5'd16: return 32'd14668;
			5'd17: return 32'd7334;
			5'd18: return 32'd3667;
			5'd19: return 32'd1833;
			5'd20: return 32'd917;
			5'd21: return 32'd458;
			5'd22: return 32'd229;
			5'd23: return 32'd115;
			default: return 32'd0;
		endcase
	endfunction

endpackage

// ----- rtl/m4t_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4t_mul: shared fixed-point multiplier
// Two-stage unit: magnitude product, then round half away from zero and
// saturate. Also returns the raw product for squared lengths.
// ----------------------------------------------------------------------------
module m4t_mul (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic signed [m4t_pkg::WORD_W-1:0] a,
	input  logic signed [m4t_pkg::WORD_W-1:0] b,
	output logic                           done,
	output logic signed [m4t_pkg::WORD_W-1:0] res,
	output logic [63:0]                    raw
);
	import m4t_pkg::*;

	logic        v_s1, done_s2;
	logic [63:0] p_s1, raw_s2;
	logic        neg_s1;
	logic signed [WORD_W-1:0] res_s2;
	logic [WORD_W-1:0] ma, mb;
	logic [63:0] prod, rnd;

	// magnitude product
	always_comb begin
		ma = mag32(a);
		mb = mag32(b);
		prod = ma * mb;
		rnd = p_s1 + 64'h0000_0000_0000_8000;
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			done_s2 <= 1'b0;
		end else begin
			v_s1 <= start;
			done_s2 <= v_s1;
		end
	end

	// product and rounding stages
	always_ff @(posedge clk) begin
		if (start) begin
			p_s1 <= prod;
			neg_s1 <= a[WORD_W-1] ^ b[WORD_W-1];
		end
		if (v_s1) begin
			raw_s2 <= p_s1;
			res_s2 <= sat_mag(rnd[63:16], neg_s1);
		end
	end

	assign done = done_s2;
	assign res = res_s2;
	assign raw = raw_s2;

endmodule

// ----- rtl/m4t_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4t_div: fixed-point divider by a length
// Restoring divider, one quotient bit per cycle; result truncates toward
// zero and saturates to the word.
// ----------------------------------------------------------------------------
module m4t_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic signed [m4t_pkg::WORD_W-1:0] x,
	input  logic [31:0]                    d,
	output logic                           done,
	output logic signed [m4t_pkg::WORD_W-1:0] res
);
	import m4t_pkg::*;

	typedef enum logic {D_IDLE, D_RUN} dstate_t;

	dstate_t     state_q;
	logic [5:0]  cnt_q;
	logic        done_q;
	logic [47:0] work_q;
	logic [31:0] rem_q, d_q;
	logic        neg_q;
	logic signed [WORD_W-1:0] res_q;
	logic [32:0] rem_sh, rem_sub;
	logic        qbit;
	logic [47:0] work_n;

	// one restoring step
	always_comb begin
		rem_sh = {rem_q, work_q[47]};
		rem_sub = rem_sh - {1'b0, d_q};
		qbit = (rem_sh >= {1'b0, d_q});
		work_n = {work_q[46:0], qbit};
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				D_IDLE: begin
					if (start) begin
						cnt_q <= '0;
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 6'd47) begin
						done_q <= 1'b1;
						state_q <= D_IDLE;
					end
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == D_IDLE && start) begin
			work_q <= {mag32(x), 16'b0};
			rem_q <= '0;
			d_q <= d;
			neg_q <= x[WORD_W-1];
		end else if (state_q == D_RUN) begin
			work_q <= work_n;
			rem_q <= qbit ? rem_sub[31:0] : rem_sh[31:0];
			if (cnt_q == 6'd47)
				res_q <= sat_mag(work_n, neg_q);
		end
	end

	assign done = done_q;
	assign res = res_q;

endmodule

// ----- rtl/m4t_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4t_sqrt: integer square root
// Digit-by-digit floor square root of a 64-bit sum of squares, one result
// bit per cycle.
// ----------------------------------------------------------------------------
module m4t_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] rad,
	output logic        done,
	output logic [31:0] res
);
	typedef enum logic {Q_IDLE, Q_RUN} qstate_t;

	qstate_t     state_q;
	logic [4:0]  cnt_q;
	logic        done_q;
	logic [63:0] rad_q;
	logic [33:0] rem_q;
	logic [31:0] root_q, res_q;
	logic [34:0] rem_sh, trial, rem_sub;
	logic        ge;
	logic [31:0] root_n;

	// one digit step
	always_comb begin
		rem_sh = {rem_q[32:0], rad_q[63:62]};
		trial = {1'b0, root_q, 2'b01};
		rem_sub = rem_sh - trial;
		ge = (rem_sh >= trial);
		root_n = {root_q[30:0], ge};
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= Q_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				Q_IDLE: begin
					if (start) begin
						cnt_q <= '0;
						state_q <= Q_RUN;
					end
				end
				Q_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'd31) begin
						done_q <= 1'b1;
						state_q <= Q_IDLE;
					end
				end
				default: state_q <= Q_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == Q_IDLE && start) begin
			rad_q <= rad;
			rem_q <= '0;
			root_q <= '0;
		end else if (state_q == Q_RUN) begin
			rad_q <= {rad_q[61:0], 2'b00};
			rem_q <= ge ? rem_sub[33:0] : rem_sh[33:0];
			root_q <= root_n;
			if (cnt_q == 5'd31)
				res_q <= root_n;
		end
	end

	assign done = done_q;
	assign res = res_q;

endmodule

// ----- rtl/m4t_cordic.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4t_cordic: sine and cosine of an angle in degrees
// Folds the angle into [-90,90] by 7 conditional subtractions, then runs a
// 24-step rotation CORDIC and rounds to the word fraction.
// ----------------------------------------------------------------------------
module m4t_cordic (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic signed [m4t_pkg::WORD_W-1:0] deg,
	output logic                           done,
	output logic signed [m4t_pkg::WORD_W-1:0] sn,
	output logic signed [m4t_pkg::WORD_W-1:0] cs
);
	import m4t_pkg::*;

	typedef enum logic [1:0] {C_IDLE, C_FOLD, C_PREP, C_ITER} cstate_t;

	cstate_t     state_q;
	logic [2:0]  k_q;
	logic [4:0]  i_q;
	logic        done_q;
	logic [31:0] r_q;
	logic        neg_q, flip_q;
	logic signed [33:0] x_q, y_q, z_q;
	logic signed [WORD_W-1:0] sn_q, cs_q;

	logic [31:0] thr;
	logic signed [33:0] a1, a2, a3, dx, dy, x_n, y_n, z_n, atan_s;
	logic        flip_n;

	// rounded and limited trig output
	function automatic logic signed [WORD_W-1:0] trig_out(input logic signed [33:0] v,
		input logic flip);
		logic signed [33:0] t;
		t = (v + 34'sd8192) >>> 14;
		if (t > 34'sd65536)
			t = 34'sd65536;
		if (t < -34'sd65536)
			t = -34'sd65536;
		if (flip)
			t = -t;
		return t[WORD_W-1:0];
	endfunction

	// folding and iteration logic
	always_comb begin
		thr = 32'(FULL_DEG) << k_q;
		a1 = neg_q ? ((r_q == '0) ? 34'sd0 : 34'(FULL_DEG) - $signed({2'b00, r_q}))
			: $signed({2'b00, r_q});
		a2 = (a1 > 34'(HALF_DEG)) ? a1 - 34'(FULL_DEG) : a1;
		flip_n = 1'b0;
		a3 = a2;
		if (a2 > 34'(QUART_DEG)) begin
			a3 = a2 - 34'(HALF_DEG);
			flip_n = 1'b1;
		end else if (a2 < -34'(QUART_DEG)) begin
			a3 = a2 + 34'(HALF_DEG);
			flip_n = 1'b1;
		end
		atan_s = $signed({2'b00, atan_deg(i_q)});
		dx = y_q >>> i_q;
		dy = x_q >>> i_q;
		if (!z_q[33]) begin
			x_n = x_q - dx;
			y_n = y_q + dy;
			z_n = z_q - atan_s;
		end else begin
			x_n = x_q + dx;
			y_n = y_q - dy;
			z_n = z_q + atan_s;
		end
	end

	// sequencer and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			k_q <= '0;
			i_q <= '0;
			done_q <= 1'b0;
			r_q <= '0;
			neg_q <= 1'b0;
			flip_q <= 1'b0;
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
			sn_q <= '0;
			cs_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				C_IDLE: begin
					if (start) begin
						r_q <= mag32(deg);
						neg_q <= deg[WORD_W-1];
						k_q <= 3'd6;
						state_q <= C_FOLD;
					end
				end
				C_FOLD: begin
					if (r_q >= thr)
						r_q <= r_q - thr;
					k_q <= k_q - 1'b1;
					if (k_q == 3'd0)
						state_q <= C_PREP;
				end
				C_PREP: begin
					z_q <= a3 <<< (24 - FRAC_W);
					flip_q <= flip_n;
					x_q <= 34'(CORDIC_X0);
					y_q <= '0;
					i_q <= '0;
					state_q <= C_ITER;
				end
				C_ITER: begin
					x_q <= x_n;
					y_q <= y_n;
					z_q <= z_n;
					i_q <= i_q + 1'b1;
					if (i_q == 5'(CORDIC_STEPS - 1)) begin
						cs_q <= trig_out(x_n, flip_q);
						sn_q <= trig_out(y_n, flip_q);
						done_q <= 1'b1;
						state_q <= C_IDLE;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign sn = sn_q;
	assign cs = cs_q;

endmodule

// ----- rtl/matrix4_transform_engine_top.sv -----
`timescale 1ns / 1ps
// A vector transform takes 16 products on the shared multiplier and premultiply
// takes 64; normalize and rotate also use the square root and the divider. One
// word at a time. Reset clears the current matrix to identity and the operand
// matrix to zero.
// ----------------------------------------------------------------------------
// matrix4_transform_engine_top: 4x4 fixed-point transform engine
// Sequencer around a shared multiplier, a divider, a square root and a
// sine/cosine unit, holding the current, operand and scratch matrices.
// ----------------------------------------------------------------------------
module matrix4_transform_engine_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// index[3:0], value_a[35:4], value_b[67:36], value_c[99:68], value_d[131:100]
	input  logic [135:0] s_axis_tdata,
	// command[2:0]
	input  logic [2:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96]
	output logic [127:0] m_axis_tdata,
	// error[0]
	output logic [0:0]   m_axis_tuser
);
	import m4t_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_WAIT, S_MM, S_MM_ACC, S_COPY, S_TV, S_TV_ACC,
		S_LEN_SQ, S_LEN_ACC, S_LEN_CHK, S_DIV, S_DIV_WR, S_X, S_X_ACC, S_COMMIT,
		S_CORD, S_ROT_A, S_ROT_B, S_ROT_C, S_ROT_D, S_DONE
	} state_t;

	typedef logic signed [WORD_W-1:0] word_t;

	state_t state_q, ret_q;
	cmd_t   cmd_q;
	word_t  va_q, vb_q, vc_q, vd_q;
	word_t  cur_q [16];
	word_t  op_q [16];
	word_t  tmp_q [16];
	word_t  u_q [3];
	word_t  res_q [4];
	word_t  acc_q, p1_q;
	logic [63:0] sum_q;
	logic [5:0] cnt_q;
	logic [1:0] r_q, c_q, col_q;
	logic [2:0] xs_q;
	logic       half_q, err_q;
	logic       out_valid_q, out_err_q;
	logic [127:0] out_data_q;

	// unit handshakes
	logic       mul_start_q, div_start_q, sqrt_start_q, cord_start_q;
	word_t      mul_a_q, mul_b_q, div_x_q;
	logic [63:0] sqrt_in_q;
	logic       mul_done, div_done, sqrt_done, cord_done;
	word_t      mul_res, div_res, cord_sn, cord_cs;
	logic [63:0] mul_raw;
	logic [31:0] sqrt_res;

	// combinational helpers
	logic [3:0] mm_oi, mm_ci, mm_ti, rot_idx;
	logic       is_rot, rot_diag, rot_neg, rot_last;
	logic [1:0] rot_k;
	word_t      src_val, tv_v, acc_mm, acc_tv, oc;
	logic [63:0] sum_n;
	logic [3:0] xd, xa1, xb1, xa2, xb2;

	m4t_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start_q), .a(mul_a_q), .b(mul_b_q),
		.done(mul_done), .res(mul_res), .raw(mul_raw)
	);

	m4t_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start_q), .x(div_x_q), .d(sqrt_res),
		.done(div_done), .res(div_res)
	);

	m4t_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start_q), .rad(sqrt_in_q),
		.done(sqrt_done), .res(sqrt_res)
	);

	m4t_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cord_start_q), .deg(vd_q),
		.done(cord_done), .sn(cord_sn), .cs(cord_cs)
	);

	// operand selection and small arithmetic
	always_comb begin
		mm_oi = {cnt_q[5:4], cnt_q[1:0]};
		mm_ci = {cnt_q[1:0], cnt_q[3:2]};
		mm_ti = cnt_q[5:2];
		is_rot = (cmd_q == CMD_ROTATE);
		case (r_q)
			2'd0: src_val = is_rot ? va_q : tmp_q[{r_q, col_q}];
			2'd1: src_val = is_rot ? vb_q : tmp_q[{r_q, col_q}];
			default: src_val = is_rot ? vc_q : tmp_q[{r_q, col_q}];
		endcase
		case (cnt_q[1:0])
			2'd0: tv_v = va_q;
			2'd1: tv_v = vb_q;
			2'd2: tv_v = vc_q;
			default: tv_v = vd_q;
		endcase
		acc_mm = sat_add((cnt_q[1:0] == 2'd0) ? '0 : acc_q, mul_res);
		acc_tv = acc_mm;
		sum_n = ((r_q == 2'd0) ? 64'd0 : sum_q) + mul_raw;
		oc = sat_sub(ONE_Q, cord_cs);
		rot_idx = {r_q, c_q};
		rot_diag = (r_q == c_q);
		rot_k = 2'd3 - r_q - c_q;
		rot_neg = (c_q == ((r_q == 2'd2) ? 2'd0 : r_q + 2'd1));
		rot_last = (r_q == 2'd2) && (c_q == 2'd2);
		// cross product terms: d = a1*b1 - a2*b2
		case (xs_q)
			3'd0: {xd, xa1, xb1, xa2, xb2} = {4'd2, 4'd4, 4'd9, 4'd8, 4'd5};
			3'd1: {xd, xa1, xb1, xa2, xb2} = {4'd6, 4'd8, 4'd1, 4'd0, 4'd9};
			3'd2: {xd, xa1, xb1, xa2, xb2} = {4'd10, 4'd0, 4'd5, 4'd4, 4'd1};
			3'd3: {xd, xa1, xb1, xa2, xb2} = {4'd1, 4'd6, 4'd8, 4'd4, 4'd10};
			3'd4: {xd, xa1, xb1, xa2, xb2} = {4'd5, 4'd10, 4'd0, 4'd8, 4'd2};
			3'd5: {xd, xa1, xb1, xa2, xb2} = {4'd9, 4'd2, 4'd4, 4'd0, 4'd6};
			default: {xd, xa1, xb1, xa2, xb2} = '0;
		endcase
	end

	// command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			cmd_q <= CMD_NOP;
			va_q <= '0;
			vb_q <= '0;
			vc_q <= '0;
			vd_q <= '0;
			for (int i = 0; i < 16; i++) begin
				cur_q[i] <= (i == 0 || i == 5 || i == 10 || i == 15) ? ONE_Q : '0;
				op_q[i] <= '0;
				tmp_q[i] <= '0;
			end
			for (int i = 0; i < 3; i++)
				u_q[i] <= '0;
			for (int i = 0; i < 4; i++)
				res_q[i] <= '0;
			acc_q <= '0;
			p1_q <= '0;
			sum_q <= '0;
			cnt_q <= '0;
			r_q <= '0;
			c_q <= '0;
			col_q <= '0;
			xs_q <= '0;
			half_q <= 1'b0;
			err_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_err_q <= 1'b0;
			out_data_q <= '0;
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			sqrt_start_q <= 1'b0;
			cord_start_q <= 1'b0;
			mul_a_q <= '0;
			mul_b_q <= '0;
			div_x_q <= '0;
			sqrt_in_q <= '0;
		end else begin
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			sqrt_start_q <= 1'b0;
			cord_start_q <= 1'b0;
			if (out_valid_q && m_axis_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				// take a word and dispatch
				S_IDLE: begin
					if (s_axis_tvalid) begin
						cmd_q <= cmd_t'(s_axis_tuser);
						va_q <= s_axis_tdata[35:4];
						vb_q <= s_axis_tdata[67:36];
						vc_q <= s_axis_tdata[99:68];
						vd_q <= s_axis_tdata[131:100];
						for (int i = 0; i < 4; i++)
							res_q[i] <= '0;
						err_q <= 1'b0;
						cnt_q <= '0;
						r_q <= '0;
						c_q <= '0;
						col_q <= '0;
						state_q <= S_DONE;
						case (cmd_t'(s_axis_tuser))
							CMD_IDENT: begin
								for (int i = 0; i < 16; i++)
									cur_q[i] <= (i == 0 || i == 5 || i == 10 || i == 15)
										? ONE_Q : '0;
							end
							CMD_WRITE: op_q[s_axis_tdata[3:0]] <= s_axis_tdata[35:4];
							CMD_PREMUL: state_q <= S_MM;
							CMD_TRANSPOSE: begin
								for (int i = 0; i < 4; i++)
									for (int j = 0; j < 4; j++)
										cur_q[4*i+j] <= cur_q[4*j+i];
							end
							CMD_NORMALIZE: begin
								for (int i = 0; i < 16; i++)
									tmp_q[i] <= cur_q[i];
								state_q <= S_LEN_SQ;
							end
							CMD_XFORM: state_q <= S_TV;
							CMD_ROTATE: state_q <= S_LEN_SQ;
							default: state_q <= S_DONE;
						endcase
					end
				end
				// wait for the busy unit
				S_WAIT: begin
					if (mul_done || div_done || sqrt_done || cord_done)
						state_q <= ret_q;
				end
				// matrix product, one term per pass
				S_MM: begin
					mul_a_q <= op_q[mm_oi];
					mul_b_q <= cur_q[mm_ci];
					mul_start_q <= 1'b1;
					ret_q <= S_MM_ACC;
					state_q <= S_WAIT;
				end
				S_MM_ACC: begin
					acc_q <= acc_mm;
					if (cnt_q[1:0] == 2'd3)
						tmp_q[mm_ti] <= acc_mm;
					cnt_q <= cnt_q + 1'b1;
					state_q <= (cnt_q == 6'd63) ? S_COPY : S_MM;
				end
				S_COPY: begin
					for (int i = 0; i < 16; i++)
						cur_q[i] <= tmp_q[i];
					state_q <= S_DONE;
				end
				// vector transform
				S_TV: begin
					mul_a_q <= cur_q[cnt_q[3:0]];
					mul_b_q <= tv_v;
					mul_start_q <= 1'b1;
					ret_q <= S_TV_ACC;
					state_q <= S_WAIT;
				end
				S_TV_ACC: begin
					acc_q <= acc_tv;
					if (cnt_q[1:0] == 2'd3)
						res_q[cnt_q[3:2]] <= acc_tv;
					cnt_q <= cnt_q + 1'b1;
					state_q <= (cnt_q[3:0] == 4'd15) ? S_DONE : S_TV;
				end
				// length of a column or axis
				S_LEN_SQ: begin
					mul_a_q <= src_val;
					mul_b_q <= src_val;
					mul_start_q <= 1'b1;
					ret_q <= S_LEN_ACC;
					state_q <= S_WAIT;
				end
				S_LEN_ACC: begin
					sum_q <= sum_n;
					if (r_q == 2'd2) begin
						sqrt_in_q <= sum_n;
						sqrt_start_q <= 1'b1;
						ret_q <= S_LEN_CHK;
						state_q <= S_WAIT;
					end else begin
						r_q <= r_q + 1'b1;
						state_q <= S_LEN_SQ;
					end
				end
				S_LEN_CHK: begin
					r_q <= '0;
					if (sqrt_res == '0) begin
						err_q <= 1'b1;
						state_q <= S_DONE;
					end else begin
						state_q <= S_DIV;
					end
				end
				// divide each component by the length
				S_DIV: begin
					div_x_q <= src_val;
					div_start_q <= 1'b1;
					ret_q <= S_DIV_WR;
					state_q <= S_WAIT;
				end
				S_DIV_WR: begin
					if (is_rot)
						u_q[r_q] <= div_res;
					else
						tmp_q[{r_q, col_q}] <= div_res;
					if (r_q == 2'd2) begin
						r_q <= '0;
						c_q <= '0;
						half_q <= 1'b0;
						xs_q <= (col_q == 2'd0) ? 3'd0 : 3'd3;
						state_q <= is_rot ? S_CORD : S_X;
					end else begin
						r_q <= r_q + 1'b1;
						state_q <= S_DIV;
					end
				end
				// cross products for re-orthonormalizing
				S_X: begin
					mul_a_q <= tmp_q[half_q ? xa2 : xa1];
					mul_b_q <= tmp_q[half_q ? xb2 : xb1];
					mul_start_q <= 1'b1;
					ret_q <= S_X_ACC;
					state_q <= S_WAIT;
				end
				S_X_ACC: begin
					if (!half_q) begin
						p1_q <= mul_res;
						half_q <= 1'b1;
						state_q <= S_X;
					end else begin
						tmp_q[xd] <= sat_sub(p1_q, mul_res);
						half_q <= 1'b0;
						if (xs_q == 3'd2) begin
							col_q <= 2'd2;
							r_q <= '0;
							state_q <= S_LEN_SQ;
						end else if (xs_q == 3'd5) begin
							state_q <= S_COMMIT;
						end else begin
							xs_q <= xs_q + 1'b1;
							state_q <= S_X;
						end
					end
				end
				S_COMMIT: begin
					for (int i = 0; i < 12; i++)
						cur_q[i] <= tmp_q[i];
					cur_q[12] <= '0;
					cur_q[13] <= '0;
					cur_q[14] <= '0;
					cur_q[15] <= ONE_Q;
					state_q <= S_DONE;
				end
				// rotation about a unit axis
				S_CORD: begin
					cord_start_q <= 1'b1;
					ret_q <= S_ROT_A;
					state_q <= S_WAIT;
				end
				S_ROT_A: begin
					mul_a_q <= u_q[r_q];
					mul_b_q <= u_q[c_q];
					mul_start_q <= 1'b1;
					ret_q <= S_ROT_B;
					state_q <= S_WAIT;
				end
				S_ROT_B: begin
					mul_a_q <= mul_res;
					mul_b_q <= oc;
					mul_start_q <= 1'b1;
					ret_q <= S_ROT_C;
					state_q <= S_WAIT;
				end
				S_ROT_C: begin
					if (rot_diag) begin
						cur_q[rot_idx] <= sat_add(mul_res, cord_cs);
						if (rot_last) begin
							cur_q[3] <= '0;
							cur_q[7] <= '0;
							cur_q[11] <= '0;
							cur_q[12] <= '0;
							cur_q[13] <= '0;
							cur_q[14] <= '0;
							cur_q[15] <= ONE_Q;
							state_q <= S_DONE;
						end else begin
							c_q <= (c_q == 2'd2) ? 2'd0 : c_q + 2'd1;
							r_q <= (c_q == 2'd2) ? r_q + 2'd1 : r_q;
							state_q <= S_ROT_A;
						end
					end else begin
						p1_q <= mul_res;
						mul_a_q <= u_q[rot_k];
						mul_b_q <= cord_sn;
						mul_start_q <= 1'b1;
						ret_q <= S_ROT_D;
						state_q <= S_WAIT;
					end
				end
				S_ROT_D: begin
					cur_q[rot_idx] <= rot_neg ? sat_sub(p1_q, mul_res) : sat_add(p1_q, mul_res);
					c_q <= (c_q == 2'd2) ? 2'd0 : c_q + 2'd1;
					r_q <= (c_q == 2'd2) ? r_q + 2'd1 : r_q;
					state_q <= S_ROT_A;
				end
				// hand the result word to the output register
				S_DONE: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						out_data_q <= {res_q[3], res_q[2], res_q[1], res_q[0]};
						out_err_q <= err_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;
	assign m_axis_tuser = out_err_q;

endmodule

// ----- tb/matrix4_transform_engine_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix4_transform_engine_top_tb: self-checking bench for the transform engine
// Drives command words through the input stream and keeps a shadow copy of
// both matrices in a bit-exact fixed-point predictor. Every returned word is
// compared field by field with the oldest expected word. The directed table
// covers identity, operand writes, premultiply, transpose, normalize,
// transform, rotate, saturation and the zero-length error cases. A random
// phase then mixes well-formed command sequences with noise.
// ----------------------------------------------------------------------------
module matrix4_transform_engine_top_tb;
	import m4t_pkg::*;

	localparam int N_RANDOM = 880;

	typedef struct packed {
		cmd_t        cmd;
		logic [3:0]  idx;
		logic signed [31:0] a, b, c, d;
	} cmd_word_t;

	typedef struct packed {
		logic signed [31:0] x, y, z, w;
		logic               err;
	} result_word_t;

	typedef struct {
		cmd_word_t    w;
		logic         known;
		result_word_t res;
	} table_row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [135:0] s_axis_tdata = '0;
	logic [2:0]   s_axis_tuser = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [127:0] m_axis_tdata;
	logic [0:0]   m_axis_tuser;

	longint cur_m[16];
	longint opr_m[16];
	result_word_t results_due[$];
	table_row_t   directed[$];
	int     n_fail = 0;
	int     n_sent = 0;
	int     n_recv = 0;
	int     n_err_seen = 0;
	int     out_gap = 0;

	localparam longint WMAX_L = 64'sd2147483647;
	localparam longint WMIN_L = -64'sd2147483648;

	const longint atan_tab[24] = '{754974720, 445687602, 235489088, 119537938,
		60000934, 30029717, 15018523, 7509720, 3754917, 1877466, 938734, 469367,
		234684, 117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

	always #4 clk = ~clk;

	matrix4_transform_engine_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	// fixed-point arithmetic shadow
	function automatic longint clampw(longint v);
		return v > WMAX_L ? WMAX_L : (v < WMIN_L ? WMIN_L : v);
	endfunction

	function automatic longint qmul(longint a, longint b);
		logic [127:0] p;
		logic [63:0]  ma, mb;
		ma = a < 0 ? -a : a;
		mb = b < 0 ? -b : b;
		p = (ma * mb + 128'(1 << 15)) >> 16;
		if (p > 128'(WMAX_L) + ((a < 0) != (b < 0) ? 1 : 0))
			return ((a < 0) != (b < 0)) ? WMIN_L : WMAX_L;
		return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
	endfunction

	function automatic longint qdiv(longint x, longint len);
		logic [127:0] q;
		logic [63:0]  m;
		m = x < 0 ? -x : x;
		q = (128'(m) << 16) / len;
		if (x < 0)
			return q > (128'(WMAX_L) + 128'd1) ? WMIN_L : -longint'(q);
		return q > 128'(WMAX_L) ? WMAX_L : longint'(q);
	endfunction

	function automatic longint len3(longint a, longint b, longint c);
		logic [127:0] n;
		logic [63:0]  r, cand;
		n = a * a + b * b + c * c;
		r = 0;
		for (int i = 33; i >= 0; i--) begin
			cand = r | (64'd1 << i);
			if (128'(cand) * cand <= n)
				r = cand;
		end
		return longint'(r);
	endfunction

	function automatic longint trig_round(longint v, bit flip);
		v = (v + (1 << 13)) >>> 14;
		if (v > 65536) v = 65536;
		if (v < -65536) v = -65536;
		return flip ? -v : v;
	endfunction

	task automatic calc_sin_cos(input longint deg, output longint sn, output longint cs);
		longint fullr, a, z, x, y, dx, dy;
		bit flip;
		fullr = 360 * 65536;
		a = deg % fullr;
		x = CORDIC_X0;
		y = 0;
		flip = 0;
		if (a < 0) a += fullr;
		if (a > 180 * 65536) a -= fullr;
		if (a > 90 * 65536) begin
			a -= 180 * 65536;
			flip = 1;
		end else if (a < -90 * 65536) begin
			a += 180 * 65536;
			flip = 1;
		end
		z = a * 256;
		for (int i = 0; i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_tab[i];
			end else begin
				x += dx; y -= dy; z += atan_tab[i];
			end
		end
		cs = trig_round(x, flip);
		sn = trig_round(y, flip);
	endtask

	function automatic bit norm_col(ref longint m[16], input int col);
		longint l;
		l = len3(m[col], m[4 + col], m[8 + col]);
		if (l == 0)
			return 0;
		for (int r = 0; r < 3; r++)
			m[4 * r + col] = qdiv(m[4 * r + col], l);
		return 1;
	endfunction

	function automatic longint qsub(longint a, longint b);
		return clampw(a - b);
	endfunction

	function automatic longint qadd(longint a, longint b);
		return clampw(a + b);
	endfunction

	// next result of the engine for one command word, updating the shadow state
	task automatic predict_engine(input cmd_word_t w, output result_word_t r);
		longint v[4], t[16], s, u[3], sn, cs, oc, l;
		v[0] = longint'(w.a); v[1] = longint'(w.b); v[2] = longint'(w.c);
		v[3] = longint'(w.d);
		r = '0;
		case (w.cmd)
			CMD_IDENT:
				for (int i = 0; i < 16; i++) cur_m[i] = (i % 5 == 0) ? 65536 : 0;
			CMD_WRITE:
				opr_m[w.idx] = v[0];
			CMD_PREMUL: begin
				for (int i = 0; i < 4; i++)
					for (int j = 0; j < 4; j++) begin
						s = 0;
						for (int k = 0; k < 4; k++)
							s = qadd(s, qmul(opr_m[4 * i + k], cur_m[4 * k + j]));
						t[4 * i + j] = s;
					end
				cur_m = t;
			end
			CMD_TRANSPOSE: begin
				for (int i = 0; i < 4; i++)
					for (int j = 0; j < 4; j++) t[4 * i + j] = cur_m[4 * j + i];
				cur_m = t;
			end
			CMD_NORMALIZE: begin
				t = cur_m;
				r.err = 1;
				if (norm_col(t, 0)) begin
					t[2] = qsub(qmul(t[4], t[9]), qmul(t[8], t[5]));
					t[6] = qsub(qmul(t[8], t[1]), qmul(t[0], t[9]));
					t[10] = qsub(qmul(t[0], t[5]), qmul(t[4], t[1]));
					if (norm_col(t, 2)) begin
						t[1] = qsub(qmul(t[6], t[8]), qmul(t[4], t[10]));
						t[5] = qsub(qmul(t[10], t[0]), qmul(t[8], t[2]));
						t[9] = qsub(qmul(t[2], t[4]), qmul(t[0], t[6]));
						t[12] = 0; t[13] = 0; t[14] = 0; t[15] = 65536;
						cur_m = t;
						r.err = 0;
					end
				end
			end
			CMD_XFORM: begin
				for (int i = 0; i < 4; i++) begin
					s = 0;
					for (int j = 0; j < 4; j++) s = qadd(s, qmul(cur_m[4 * i + j], v[j]));
					case (i)
						0: r.x = 32'(s);
						1: r.y = 32'(s);
						2: r.z = 32'(s);
						default: r.w = 32'(s);
					endcase
				end
			end
			CMD_ROTATE: begin
				l = len3(v[0], v[1], v[2]);
				if (l == 0)
					r.err = 1;
				else begin
					for (int i = 0; i < 3; i++) u[i] = qdiv(v[i], l);
					calc_sin_cos(v[3], sn, cs);
					oc = qsub(65536, cs);
					for (int i = 0; i < 3; i++)
						for (int j = 0; j < 3; j++)
							cur_m[4 * i + j] = qmul(qmul(u[i], u[j]), oc);
					cur_m[0] = qadd(cur_m[0], cs);
					cur_m[5] = qadd(cur_m[5], cs);
					cur_m[10] = qadd(cur_m[10], cs);
					cur_m[1] = qsub(cur_m[1], qmul(u[2], sn));
					cur_m[2] = qadd(cur_m[2], qmul(u[1], sn));
					cur_m[4] = qadd(cur_m[4], qmul(u[2], sn));
					cur_m[6] = qsub(cur_m[6], qmul(u[0], sn));
					cur_m[8] = qsub(cur_m[8], qmul(u[1], sn));
					cur_m[9] = qadd(cur_m[9], qmul(u[0], sn));
					cur_m[3] = 0; cur_m[7] = 0; cur_m[11] = 0;
					cur_m[12] = 0; cur_m[13] = 0; cur_m[14] = 0; cur_m[15] = 65536;
				end
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint exp_v);
		n_fail++;
		$display("[%0t] mismatch %s on word %0d: got %0d expected %0d",
			$time, what, n_recv, got, exp_v);
	endtask

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 45) return 0;
		if (p < 92) return $urandom_range(1, 4);
		return $urandom_range(10, 120);
	endfunction

	// send one command word, predicting its result
	task automatic send_word(input cmd_word_t w, input logic known, input result_word_t want);
		result_word_t r;
		int g;
		g = gap_len();
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= w.cmd;
		s_axis_tdata  <= {4'b0, w.d, w.c, w.b, w.a, w.idx};
		do @(posedge clk); while (!s_axis_tready);
		predict_engine(w, r);
		if (known && r != want) begin
			n_fail++;
			$display("[%0t] table row %0d disagrees with predictor", $time, n_sent);
		end
		results_due.push_back(r);
		n_sent++;
	endtask

	function automatic cmd_word_t mk(cmd_t c, logic [3:0] i, int a, int b, int cc, int d);
		cmd_word_t w;
		w.cmd = c; w.idx = i; w.a = a; w.b = b; w.c = cc; w.d = d;
		return w;
	endfunction

	task automatic add_row(input cmd_word_t w, input logic known, input result_word_t r);
		table_row_t t;
		t.w = w; t.known = known; t.res = r;
		directed.push_back(t);
	endtask

	function automatic logic signed [31:0] rnd_val();
		int p;
		p = $urandom_range(0, 9);
		if (p < 5) return $signed($urandom_range(0, 262143)) - 131072;
		if (p < 7) return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
		if (p < 8) return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
		return $urandom;
	endfunction

	// output side: random stall and compare
	always @(posedge clk) begin
		result_word_t got, want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.x = m_axis_tdata[31:0];
				got.y = m_axis_tdata[63:32];
				got.z = m_axis_tdata[95:64];
				got.w = m_axis_tdata[127:96];
				got.err = m_axis_tuser[0];
				n_err_seen += got.err;
				if (results_due.size() == 0) begin
					n_fail++;
					$display("[%0t] unexpected result word", $time);
				end else begin
					want = results_due.pop_front();
					if (got.x != want.x) report_mismatch("out_x", got.x, want.x);
					if (got.y != want.y) report_mismatch("out_y", got.y, want.y);
					if (got.z != want.z) report_mismatch("out_z", got.z, want.z);
					if (got.w != want.w) report_mismatch("out_w", got.w, want.w);
					if (got.err != want.err) report_mismatch("error", got.err, want.err);
				end
				n_recv++;
			end
			// stall runs: mostly none or short, a few long
			if (out_gap > 0) begin
				out_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				out_gap = gap_len();
				m_axis_tready <= (out_gap == 0);
			end
		end
	end

	// stimulus
	initial begin
		result_word_t z, e1, xv;
		cmd_word_t    w;
		int           k;
		z = '0;
		e1 = '0; e1.err = 1;
		xv = '0; xv.x = 32'sh0001_0000; xv.y = -32'sh0002_0000; xv.z = 32'sh0000_8000;
		xv.w = 32'sh0001_0000;
		for (int i = 0; i < 16; i++) opr_m[i] = 0;
		for (int i = 0; i < 16; i++) cur_m[i] = (i % 5 == 0) ? 65536 : 0;

		// directed table
		add_row(mk(CMD_XFORM, 0, 32'sh10000, -32'sh20000, 32'sh8000, 32'sh10000), 1, xv);
		add_row(mk(CMD_PREMUL, 0, 0, 0, 0, 0), 1, z);
		add_row(mk(CMD_NORMALIZE, 0, 0, 0, 0, 0), 1, e1);
		add_row(mk(CMD_XFORM, 15, 32'h7fffffff, 32'h80000000, -1, 1), 0, z);
		add_row(mk(CMD_IDENT, 0, 0, 0, 0, 0), 1, z);
		add_row(mk(CMD_ROTATE, 0, 0, 0, 0, 32'sh5a0000), 1, e1);
		add_row(mk(CMD_ROTATE, 0, 0, 0, 32'sh10000, 32'sh5a0000), 0, z);
		add_row(mk(CMD_XFORM, 0, 32'sh10000, 0, 0, 32'sh10000), 0, z);
		add_row(mk(CMD_TRANSPOSE, 0, 0, 0, 0, 0), 1, z);
		add_row(mk(CMD_ROTATE, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h80000000), 0, z);
		add_row(mk(CMD_NORMALIZE, 0, 0, 0, 0, 0), 0, z);
		add_row(mk(CMD_ROTATE, 0, 32'sh30000, 32'sh40000, 0, -32'sh870000), 0, z);
		add_row(mk(CMD_WRITE, 0, 32'h7fffffff, 0, 0, 0), 1, z);
		add_row(mk(CMD_WRITE, 5, 32'h80000000, 0, 0, 0), 1, z);
		add_row(mk(CMD_WRITE, 10, 32'sh20000, 0, 0, 0), 1, z);
		add_row(mk(CMD_WRITE, 15, 32'sh10000, 0, 0, 0), 1, z);
		add_row(mk(CMD_PREMUL, 0, 0, 0, 0, 0), 1, z);
		add_row(mk(CMD_PREMUL, 0, 0, 0, 0, 0), 1, z);
		add_row(mk(CMD_XFORM, 0, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
			32'h80000000), 0, z);
		add_row(mk(CMD_NORMALIZE, 0, 0, 0, 0, 0), 0, z);
		add_row(mk(CMD_NOP, 9, -1, -1, -1, -1), 1, z);
		add_row(mk(CMD_IDENT, 0, 0, 0, 0, 0), 1, z);
		add_row(mk(CMD_ROTATE, 0, 0, 0, 32'sh10000, 32'sh1680000), 0, z);
		add_row(mk(CMD_NORMALIZE, 0, 0, 0, 0, 0), 0, z);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) send_word(directed[i].w, directed[i].known, directed[i].res);

		// random: mostly well-formed sequences, some noise
		k = 0;
		while (k < N_RANDOM) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					for (int i = 0; i < 4; i++) begin
						send_word(mk(CMD_WRITE, 4'($urandom), rnd_val(), $urandom,
							$urandom, $urandom), 0, z);
						k++;
					end
					send_word(mk(CMD_PREMUL, 4'($urandom), $urandom, $urandom,
						$urandom, $urandom), 0, z);
					k++;
				end
				3, 4: begin
					send_word(mk(CMD_ROTATE, 4'($urandom), rnd_val(), rnd_val(), rnd_val(),
						$urandom_range(0, 3) == 0 ? $urandom : $signed($urandom_range(0,
						720 << 16)) - (360 << 16)), 0, z);
					k++;
				end
				5, 6: begin
					w = mk(CMD_XFORM, 4'($urandom), rnd_val(), rnd_val(), rnd_val(), rnd_val());
					send_word(w, 0, z);
					k++;
				end
				default: begin
					w = mk(cmd_t'($urandom_range(0, 7)), 4'($urandom), rnd_val(), $urandom,
						$urandom, $urandom);
					send_word(w, 0, z);
					k++;
				end
			endcase
		end

		s_axis_tvalid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
		$display("covered %0d command words, %0d result words, %0d with error set",
			n_sent, n_recv, n_err_seen);
		if (n_fail == 0 && results_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// run limit
	initial begin
		#(64'd8 * 64'd5000000);
		$display("timeout with %0d results outstanding", results_due.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
